FILE: rtl/core/mmit_pkg.sv
package mmit_pkg;

	// Command codes
	localparam logic [3:0] CMD_TICK      = 4'd0;
	localparam logic [3:0] CMD_START     = 4'd1;
	localparam logic [3:0] CMD_STOP      = 4'd2;
	localparam logic [3:0] CMD_PAUSE     = 4'd3;
	localparam logic [3:0] CMD_RESUME    = 4'd4;
	localparam logic [3:0] CMD_RETRIGGER = 4'd5;
	localparam logic [3:0] CMD_RESTART   = 4'd6;
	localparam logic [3:0] CMD_UPDATE    = 4'd7;
	localparam logic [3:0] CMD_CLEAR     = 4'd8;
	localparam logic [3:0] CMD_QUERY     = 4'd9;

	// Timer modes
	localparam logic [1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_RETRIG   = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_ARG   = 2'd1;
	localparam logic [1:0] ERR_STATE = 2'd2;

	typedef struct packed {
		logic [3:0]  command;
		logic [31:0] period;
		logic [1:0]  mode;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [1:0]  error_code;
		logic        is_running;
		logic        is_paused;
		logic [31:0] elapsed_ticks;
		logic [31:0] remaining_ticks;
		logic [31:0] fire_count;
	} rsp_t;

endpackage

FILE: rtl/core/mmit_exec.sv
// Timer state and command execution: one request per enabled cycle.
module mmit_exec #(
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  mmit_pkg::req_t req,
	output mmit_pkg::rsp_t rsp
);

	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic                  armed_q, held_q;
	logic [1:0]            mode_q;
	logic [COUNT_BITS-1:0] timeout_q, elapsed_q, total_q;

	logic                  armed_d, held_d;
	logic [1:0]            mode_d;
	logic [COUNT_BITS-1:0] timeout_d, elapsed_d, total_d;
	logic                  fired;
	logic [1:0]            err;

	logic                  running;
	logic [COUNT_BITS-1:0] period_sat, el_inc, el_out, rem_out;
	logic                  period_over;

	assign running = armed_q && !held_q;

	// Saturate the request period to the counter width
	assign period_over = 64'(req.period) > 64'(CMAX);
	assign period_sat  = period_over ? CMAX : COUNT_BITS'(req.period);

	assign el_inc = (elapsed_q != CMAX) ? elapsed_q + 1'b1 : elapsed_q;

	// Next-state decode
	always_comb begin
		armed_d   = armed_q;
		held_d    = held_q;
		mode_d    = mode_q;
		timeout_d = timeout_q;
		elapsed_d = elapsed_q;
		total_d   = total_q;
		fired     = 1'b0;
		err       = mmit_pkg::ERR_OK;
		case (req.command)
			mmit_pkg::CMD_TICK: begin
				if (running) begin
					if (el_inc >= timeout_q) begin
						fired     = 1'b1;
						elapsed_d = '0;
						if (total_q != CMAX)
							total_d = total_q + 1'b1;
						if (mode_q != mmit_pkg::MODE_PERIODIC)
							armed_d = 1'b0;
					end else begin
						elapsed_d = el_inc;
					end
				end
			end
			mmit_pkg::CMD_START: begin
				if (req.period == '0 || req.mode > mmit_pkg::MODE_RETRIG) begin
					err = mmit_pkg::ERR_ARG;
				end else begin
					mode_d    = req.mode;
					timeout_d = period_sat;
					elapsed_d = '0;
					armed_d   = 1'b1;
					held_d    = 1'b0;
				end
			end
			mmit_pkg::CMD_STOP: begin
				armed_d   = 1'b0;
				held_d    = 1'b0;
				elapsed_d = '0;
			end
			mmit_pkg::CMD_PAUSE: begin
				if (running)
					held_d = 1'b1;
				else
					err = mmit_pkg::ERR_STATE;
			end
			mmit_pkg::CMD_RESUME: begin
				if (armed_q && held_q)
					held_d = 1'b0;
				else
					err = mmit_pkg::ERR_STATE;
			end
			mmit_pkg::CMD_RETRIGGER: begin
				if (!armed_q || mode_q != mmit_pkg::MODE_RETRIG || timeout_q == '0) begin
					err = mmit_pkg::ERR_STATE;
				end else begin
					elapsed_d = '0;
					held_d    = 1'b0;
				end
			end
			mmit_pkg::CMD_RESTART: begin
				if (timeout_q == '0) begin
					err = mmit_pkg::ERR_STATE;
				end else begin
					elapsed_d = '0;
					armed_d   = 1'b1;
					held_d    = 1'b0;
				end
			end
			mmit_pkg::CMD_UPDATE: begin
				if (req.period == '0) begin
					err = mmit_pkg::ERR_ARG;
				end else begin
					timeout_d = period_sat;
					if (armed_q) begin
						elapsed_d = '0;
						held_d    = 1'b0;
					end
				end
			end
			mmit_pkg::CMD_CLEAR: begin
				total_d = '0;
			end
			mmit_pkg::CMD_QUERY: begin
			end
			default: begin
				err = mmit_pkg::ERR_ARG;
			end
		endcase
	end

	// Status after the command
	assign el_out  = armed_d ? elapsed_d : '0;
	assign rem_out = (el_out >= timeout_d) ? '0 : timeout_d - el_out;

	always_comb begin
		rsp.fired           = fired;
		rsp.error_code      = err;
		rsp.is_running      = armed_d && !held_d;
		rsp.is_paused       = armed_d && held_d;
		rsp.elapsed_ticks   = 32'(el_out);
		rsp.remaining_ticks = 32'(rem_out);
		rsp.fire_count      = 32'(total_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			held_q    <= 1'b0;
			mode_q    <= mmit_pkg::MODE_ONESHOT;
			timeout_q <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
		end else if (en) begin
			armed_q   <= armed_d;
			held_q    <= held_d;
			mode_q    <= mode_d;
			timeout_q <= timeout_d;
			elapsed_q <= elapsed_d;
			total_q   <= total_d;
		end
	end

endmodule

FILE: rtl/core/multi_mode_interval_timer.sv
// Path: input register, then execute step, then result register that holds until taken.
// Throughput: one request per cycle unless the result stalls; the execute step between
//   the two registers (increment, compare, remaining-time subtract) sets the clock budget.
// Reset: arst_n clears the timer (disarmed, one-shot, zero timeout, counts and
//   fire total), both pipeline valids; ready for requests right after reset.
module multi_mode_interval_timer #(
	parameter int COUNT_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mmit_pkg::req_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output mmit_pkg::rsp_t res
);

	logic           cmd_valid_s1;
	mmit_pkg::req_t cmd_s1;
	logic           res_valid_s2;
	mmit_pkg::rsp_t res_s2;
	mmit_pkg::rsp_t exec_rsp;
	logic           advance;

	// Stage 1 moves on when the result register is free or draining
	assign advance   = cmd_valid_s1 && (!res_valid_s2 || res_ready);
	assign cmd_ready = !cmd_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			cmd_s1 <= cmd;
	end

	mmit_exec #(
		.COUNT_BITS(COUNT_BITS)
	) u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (cmd_s1),
		.rsp    (exec_rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= exec_rsp;
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

FILE: rtl/core/mmit_checker.sv
// Port-level checks on the timer results
module mmit_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input mmit_pkg::rsp_t res
);

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Running and paused never both, and the error code is a defined one
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.is_running && res.is_paused)
			&& res.error_code != 2'd3)
		else $error("bad status combination");

	// An expiry restarts the count and is not an error
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fired |-> res.elapsed_ticks == '0 && !res.is_paused
			&& res.error_code == mmit_pkg::ERR_OK)
		else $error("fire with bad state");

	// Disarmed timer shows no elapsed time
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_running && !res.is_paused |-> res.elapsed_ticks == '0)
		else $error("elapsed nonzero while disarmed");

endmodule

bind multi_mode_interval_timer mmit_checker u_mmit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

FILE: tb/multi_mode_interval_timer_test.sv
module multi_mode_interval_timer_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes the package does not name: the mode a start rejects, unused commands
	localparam logic [1:0] MODE_BAD      = 2'd3;
	localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
	localparam int         RANDOM_REQS   = 1850;

	typedef struct {
		mmit_pkg::req_t req;
		bit             typed;
		mmit_pkg::rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	mmit_pkg::req_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	mmit_pkg::rsp_t res;

	// Timer state as the predictor sees it
	logic        t_armed = 1'b0;
	logic        t_held = 1'b0;
	logic [1:0]  t_mode = mmit_pkg::MODE_ONESHOT;
	logic [31:0] t_timeout = '0;
	logic [31:0] t_elapsed = '0;
	logic [31:0] t_fires = '0;

	mmit_pkg::rsp_t pending_status[$];
	dir_row_t       dir_rows[$];
	bit             steady = 1'b0;
	int             errors = 0;
	int             reqs_sent = 0;
	int             expiries_seen = 0;
	int             rejects_seen = 0;

	multi_mode_interval_timer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always #5 clk = ~clk;

	// Load the timer: clear elapsed, run unpaused
	task automatic arm_timer(input logic [31:0] period, input logic [1:0] mode);
		t_mode = mode;
		t_timeout = period;
		t_elapsed = '0;
		t_armed = 1'b1;
		t_held = 1'b0;
	endtask

	// Apply one request to the timer state and build the status it reports
	task automatic predict_status(input mmit_pkg::req_t r, output mmit_pkg::rsp_t o);
		logic        fired;
		logic [1:0]  err;
		logic [31:0] el;
		fired = 1'b0;
		err = mmit_pkg::ERR_OK;
		case (r.command)
			mmit_pkg::CMD_TICK: begin
				if (t_armed && !t_held) begin
					if (t_elapsed != '1)
						t_elapsed++;
					if (t_elapsed >= t_timeout) begin
						fired = 1'b1;
						if (t_fires != '1)
							t_fires++;
						t_elapsed = '0;
						if (t_mode != mmit_pkg::MODE_PERIODIC)
							t_armed = 1'b0;
					end
				end
			end
			mmit_pkg::CMD_START: begin
				if (r.period == '0 || r.mode > mmit_pkg::MODE_RETRIG)
					err = mmit_pkg::ERR_ARG;
				else
					arm_timer(r.period, r.mode);
			end
			mmit_pkg::CMD_STOP: begin
				t_armed = 1'b0;
				t_held = 1'b0;
				t_elapsed = '0;
			end
			mmit_pkg::CMD_PAUSE: begin
				if (t_armed && !t_held)
					t_held = 1'b1;
				else
					err = mmit_pkg::ERR_STATE;
			end
			mmit_pkg::CMD_RESUME: begin
				if (t_armed && t_held)
					t_held = 1'b0;
				else
					err = mmit_pkg::ERR_STATE;
			end
			mmit_pkg::CMD_RETRIGGER: begin
				if (!t_armed || t_mode != mmit_pkg::MODE_RETRIG || t_timeout == '0) begin
					err = mmit_pkg::ERR_STATE;
				end else begin
					t_elapsed = '0;
					t_held = 1'b0;
				end
			end
			mmit_pkg::CMD_RESTART: begin
				if (t_timeout == '0)
					err = mmit_pkg::ERR_STATE;
				else
					arm_timer(t_timeout, t_mode);
			end
			mmit_pkg::CMD_UPDATE: begin
				if (r.period == '0)
					err = mmit_pkg::ERR_ARG;
				else if (t_armed)
					arm_timer(r.period, t_mode);
				else
					t_timeout = r.period;
			end
			mmit_pkg::CMD_CLEAR: t_fires = '0;
			mmit_pkg::CMD_QUERY: ;
			default: err = mmit_pkg::ERR_ARG;
		endcase
		el = t_armed ? t_elapsed : '0;
		o.fired = fired;
		o.error_code = err;
		o.is_running = t_armed && !t_held;
		o.is_paused = t_armed && t_held;
		o.elapsed_ticks = el;
		o.remaining_ticks = (el >= t_timeout) ? '0 : t_timeout - el;
		o.fire_count = t_fires;
	endtask

	function automatic dir_row_t dir(input logic [3:0] c, input logic [31:0] p,
			input logic [1:0] m, input bit typed = 1'b0, input mmit_pkg::rsp_t want = '0);
		dir_row_t row;
		row.req.command = c;
		row.req.period = p;
		row.req.mode = m;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// Offer one request, wait for the handshake, then record what it should report
	task automatic send_request(input mmit_pkg::req_t r, input bit typed,
			input mmit_pkg::rsp_t want);
		mmit_pkg::rsp_t predicted;
		while (!steady && $urandom_range(0, 99) < 33) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= r;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		predict_status(r, predicted);
		pending_status.push_back(typed ? want : predicted);
		reqs_sent++;
	endtask

	// Result side: check against the oldest expectation, then pick next ready
	always @(posedge clk) begin
		mmit_pkg::rsp_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_status.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (res.fired !== want.fired) begin
					$error("fired: expected %0d, got %0d", want.fired, res.fired);
					errors++;
				end
				if (res.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						res.error_code);
					errors++;
				end
				if (res.is_running !== want.is_running) begin
					$error("is_running: expected %0d, got %0d", want.is_running,
						res.is_running);
					errors++;
				end
				if (res.is_paused !== want.is_paused) begin
					$error("is_paused: expected %0d, got %0d", want.is_paused,
						res.is_paused);
					errors++;
				end
				if (res.elapsed_ticks !== want.elapsed_ticks) begin
					$error("elapsed_ticks: expected %0d, got %0d", want.elapsed_ticks,
						res.elapsed_ticks);
					errors++;
				end
				if (res.remaining_ticks !== want.remaining_ticks) begin
					$error("remaining_ticks: expected %0d, got %0d", want.remaining_ticks,
						res.remaining_ticks);
					errors++;
				end
				if (res.fire_count !== want.fire_count) begin
					$error("fire_count: expected %0d, got %0d", want.fire_count,
						res.fire_count);
					errors++;
				end
				if (res.fired === 1'b1)
					expiries_seen++;
				if (res.error_code !== mmit_pkg::ERR_OK)
					rejects_seen++;
			end
		end
		res_ready <= steady || ($urandom_range(0, 99) >= 33);
	end

	initial begin
		mmit_pkg::req_t r;
		int             sel;
		int             pick;
		// Directed: reset error paths, one-shot fire, periodic fire and pause, retrigger when paused
		dir_rows.push_back(dir(mmit_pkg::CMD_QUERY, '0, mmit_pkg::MODE_ONESHOT, 1'b1, '0));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '1, MODE_BAD, 1'b1, '0));
		dir_rows.push_back(dir(mmit_pkg::CMD_PAUSE, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_STATE, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_RESUME, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_STATE, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_RETRIGGER, '0, mmit_pkg::MODE_RETRIG, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_STATE, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_RESTART, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_STATE, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_START, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_ARG, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_START, 32'd5, MODE_BAD, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_ARG, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(CMD_UNUSED_LO, 32'd5, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_ARG, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(CMD_UNUSED_HI, '1, MODE_BAD, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_ARG, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_UPDATE, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_ARG, 1'b0, 1'b0,
				32'd0, 32'd0, 32'd0}));
		// disarmed update only stores the timeout
		dir_rows.push_back(dir(mmit_pkg::CMD_UPDATE, 32'd3, mmit_pkg::MODE_PERIODIC, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_OK, 1'b0, 1'b0,
				32'd0, 32'd3, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_RESTART, '0, MODE_BAD));
		dir_rows.push_back(dir(mmit_pkg::CMD_START, 32'd1, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b0, mmit_pkg::ERR_OK, 1'b1, 1'b0,
				32'd0, 32'd1, 32'd0}));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '0, mmit_pkg::MODE_ONESHOT, 1'b1,
			mmit_pkg::rsp_t'{1'b1, mmit_pkg::ERR_OK, 1'b0, 1'b0,
				32'd0, 32'd1, 32'd1}));
		dir_rows.push_back(dir(mmit_pkg::CMD_START, 32'd2, mmit_pkg::MODE_PERIODIC));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_PAUSE, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_RESUME, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_START, '1, mmit_pkg::MODE_RETRIG));
		dir_rows.push_back(dir(mmit_pkg::CMD_TICK, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_PAUSE, '0, mmit_pkg::MODE_ONESHOT));
		// retrigger on a paused timer also resumes it
		dir_rows.push_back(dir(mmit_pkg::CMD_RETRIGGER, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_UPDATE, '1, MODE_BAD));
		dir_rows.push_back(dir(mmit_pkg::CMD_STOP, '0, mmit_pkg::MODE_ONESHOT));
		dir_rows.push_back(dir(mmit_pkg::CMD_CLEAR, '0, mmit_pkg::MODE_ONESHOT));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// Random: ticks are the most common command, against mostly short periods so the timer fires often
		for (int n = 0; n < RANDOM_REQS; n++) begin
			steady = (n >= 700 && n < 1000);
			r.period = $urandom;
			r.mode = 2'($urandom_range(0, 3));
			sel = $urandom_range(0, 99);
			pick = $urandom_range(0, 99);
			if (sel < 45)
				r.command = mmit_pkg::CMD_TICK;
			else if (sel < 57)
				r.command = mmit_pkg::CMD_START;
			else if (sel < 61)
				r.command = mmit_pkg::CMD_STOP;
			else if (sel < 67)
				r.command = mmit_pkg::CMD_PAUSE;
			else if (sel < 73)
				r.command = mmit_pkg::CMD_RESUME;
			else if (sel < 80)
				r.command = mmit_pkg::CMD_RETRIGGER;
			else if (sel < 85)
				r.command = mmit_pkg::CMD_RESTART;
			else if (sel < 91)
				r.command = mmit_pkg::CMD_UPDATE;
			else if (sel < 94)
				r.command = mmit_pkg::CMD_CLEAR;
			else if (sel < 98)
				r.command = mmit_pkg::CMD_QUERY;
			else
				r.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			if (r.command == mmit_pkg::CMD_START || r.command == mmit_pkg::CMD_UPDATE) begin
				if (pick < 2)
					r.period = '0;
				else if (pick < 85)
					r.period = $urandom_range(1, 12);
			end
			if (r.command == mmit_pkg::CMD_START)
				r.mode = ($urandom_range(0, 19) == 0) ? MODE_BAD :
					2'($urandom_range(mmit_pkg::MODE_ONESHOT, mmit_pkg::MODE_RETRIG));
			send_request(r, 1'b0, '0);
		end
		steady = 1'b0;
		cmd_valid <= 1'b0;

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests (%0d directed), every command and mode incl. rejects",
			reqs_sent, dir_rows.size());
		$display("%0d expiries and %0d rejected requests seen at the output",
			expiries_seen, rejects_seen);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending_status.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
